// ===== rtl/pcl_pkg.sv =====
`timescale 1ns / 1ps

package pcl_pkg;

	// Widths fixed by the item fields.
	localparam int unsigned FUNC_W  = 3;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned POS_W   = 7;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned COUNT_W = 7;
	// A cell index; six bits address at most 64 entries.
	localparam int unsigned IDX_W   = 6;

	// Operation codes carried by func.
	typedef enum logic [FUNC_W-1:0] {
		FN_INS_FRONT = 3'd0,
		FN_INS_BACK  = 3'd1,
		FN_DEL_FRONT = 3'd2,
		FN_DEL_BACK  = 3'd3,
		FN_INS_AT    = 3'd4,
		FN_DEL_AT    = 3'd5,
		FN_DUMP      = 3'd6,
		FN_NOP       = 3'd7
	} func_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// What the whole chain does in one cycle.
	typedef enum logic [1:0] {
		CH_NONE   = 2'd0,
		CH_INSERT = 2'd1,
		CH_DELETE = 2'd2,
		CH_ROTATE = 2'd3
	} chain_op_t;

	// Broadcast to every cell.
	typedef struct packed {
		chain_op_t        op;
		logic [IDX_W-1:0] idx;   // insert or delete point
		logic [IDX_W-1:0] last;  // index of the tail entry, for rotation
	} chain_ctrl_t;

	// Controller states.
	typedef enum logic {
		S_IDLE = 1'b0,
		S_DUMP = 1'b1
	} state_t;

endpackage

// ===== rtl/pcl_cell.sv =====
`timescale 1ns / 1ps

module pcl_cell #(
	parameter int unsigned INDEX = 0
) (
	input  logic                       clk,
	input  pcl_pkg::chain_ctrl_t       ctrl,
	input  logic [pcl_pkg::DATA_W-1:0] new_value,
	input  logic [pcl_pkg::DATA_W-1:0] left_value,
	input  logic [pcl_pkg::DATA_W-1:0] right_value,
	input  logic [pcl_pkg::DATA_W-1:0] head_value,
	output logic [pcl_pkg::DATA_W-1:0] entry
);

	localparam logic [pcl_pkg::IDX_W-1:0] MY_IDX = pcl_pkg::IDX_W'(INDEX);

	logic [pcl_pkg::DATA_W-1:0] entry_q;
	logic [pcl_pkg::DATA_W-1:0] entry_d;

	// Each cell picks its own source from the broadcast operation and its place.
	always_comb begin
		entry_d = entry_q;
		unique case (ctrl.op)
			pcl_pkg::CH_INSERT: begin
				if (MY_IDX == ctrl.idx) begin
					entry_d = new_value;
				end else if (MY_IDX > ctrl.idx) begin
					entry_d = left_value;
				end
			end
			pcl_pkg::CH_DELETE: begin
				if (MY_IDX >= ctrl.idx) begin
					entry_d = right_value;
				end
			end
			pcl_pkg::CH_ROTATE: begin
				if (MY_IDX == ctrl.last) begin
					entry_d = head_value;
				end else if (MY_IDX < ctrl.last) begin
					entry_d = right_value;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule

// ===== rtl/positional_circular_list_core.sv =====
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in       in_valid / in_ready    func, value, position
// out      out_valid / out_ready  status, count, item_value, last_item
//
// Every operation but a dump gives one result item, back to back while out_ready is high.
// A dump of N entries first enters the dump state, then gives N result items, one per
// cycle while out_ready is high; the chain rotates once per item and is restored at the end.
// No input is taken until the last dump item is loaded.
// Reset clears the entry count and the handshake state; entries are not cleared.
// A stalled result holds in the output register; input is taken again once it
// is taken or while it is being taken.

module positional_circular_list_core #(
	parameter int unsigned CAPACITY = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [pcl_pkg::FUNC_W-1:0]  func,
	input  logic signed [pcl_pkg::DATA_W-1:0] value,
	input  logic [pcl_pkg::POS_W-1:0]   position,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [pcl_pkg::STAT_W-1:0]  status,
	output logic [pcl_pkg::COUNT_W-1:0] count,
	output logic signed [pcl_pkg::DATA_W-1:0] item_value,
	output logic                        last_item
);

	localparam logic [pcl_pkg::COUNT_W-1:0] CAP = pcl_pkg::COUNT_W'(CAPACITY);

	pcl_pkg::state_t state_q, state_d;
	logic [pcl_pkg::COUNT_W-1:0] len_q, len_d;
	logic [pcl_pkg::COUNT_W-1:0] remain_q, remain_d;
	logic                        out_valid_q;
	logic [pcl_pkg::STAT_W-1:0]  status_q;
	logic [pcl_pkg::COUNT_W-1:0] count_q;
	logic [pcl_pkg::DATA_W-1:0]  item_value_q;
	logic                        last_item_q;

	logic                        out_free;
	logic                        fire_in;
	logic                        out_load;
	pcl_pkg::status_t            status_d;
	logic [pcl_pkg::DATA_W-1:0]  item_value_d;
	logic                        last_item_d;
	logic                        start_dump;
	pcl_pkg::chain_ctrl_t        ctrl;

	logic [pcl_pkg::DATA_W-1:0]  entry [CAPACITY];
	logic                        full;
	logic                        empty;
	logic [pcl_pkg::IDX_W-1:0]   len_idx;
	logic [pcl_pkg::IDX_W-1:0]   tail_idx;
	logic [pcl_pkg::IDX_W-1:0]   pos_idx;
	logic [pcl_pkg::POS_W-1:0]   pos_m1;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == pcl_pkg::S_IDLE) && out_free;
	assign fire_in  = in_valid && in_ready;

	assign full     = (len_q >= CAP);
	assign empty    = (len_q == '0);
	assign len_idx  = len_q[pcl_pkg::IDX_W-1:0];
	assign tail_idx = pcl_pkg::IDX_W'(len_q - 7'd1);
	assign pos_m1   = position - 7'd1;
	assign pos_idx  = pos_m1[pcl_pkg::IDX_W-1:0];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcl_pkg::S_IDLE: begin
				if (start_dump) begin
					state_d = pcl_pkg::S_DUMP;
				end
			end
			pcl_pkg::S_DUMP: begin
				if (out_free && remain_q == 7'd1) begin
					state_d = pcl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pcl_pkg::S_IDLE;
			end
		endcase
	end

	// Decode of the operation, chain control and the next result item.
	always_comb begin
		ctrl         = '{op: pcl_pkg::CH_NONE, idx: '0, last: tail_idx};
		len_d        = len_q;
		remain_d     = remain_q;
		out_load     = 1'b0;
		status_d     = pcl_pkg::ST_OK;
		item_value_d = '0;
		last_item_d  = 1'b1;
		start_dump   = 1'b0;
		unique case (state_q)
			pcl_pkg::S_IDLE: begin
				if (fire_in) begin
					out_load = 1'b1;
					unique case (pcl_pkg::func_t'(func))
						pcl_pkg::FN_INS_FRONT, pcl_pkg::FN_INS_BACK: begin
							if (full) begin
								status_d = pcl_pkg::ST_FULL;
							end else begin
								ctrl.op  = pcl_pkg::CH_INSERT;
								ctrl.idx = (pcl_pkg::func_t'(func) == pcl_pkg::FN_INS_FRONT)
									? '0 : len_idx;
								len_d    = len_q + 7'd1;
							end
						end
						pcl_pkg::FN_DEL_FRONT, pcl_pkg::FN_DEL_BACK: begin
							if (empty) begin
								status_d = pcl_pkg::ST_EMPTY;
							end else begin
								ctrl.op  = pcl_pkg::CH_DELETE;
								ctrl.idx = (pcl_pkg::func_t'(func) == pcl_pkg::FN_DEL_FRONT)
									? '0 : tail_idx;
								len_d    = len_q - 7'd1;
							end
						end
						pcl_pkg::FN_INS_AT: begin
							if (position == '0 || position > len_q + 7'd1) begin
								status_d = pcl_pkg::ST_BADPOS;
							end else if (full) begin
								status_d = pcl_pkg::ST_FULL;
							end else begin
								ctrl.op  = pcl_pkg::CH_INSERT;
								ctrl.idx = pos_idx;
								len_d    = len_q + 7'd1;
							end
						end
						pcl_pkg::FN_DEL_AT: begin
							if (position == '0 || position > len_q) begin
								status_d = pcl_pkg::ST_BADPOS;
							end else begin
								ctrl.op  = pcl_pkg::CH_DELETE;
								ctrl.idx = pos_idx;
								len_d    = len_q - 7'd1;
							end
						end
						pcl_pkg::FN_DUMP: begin
							if (empty) begin
								status_d = pcl_pkg::ST_EMPTY;
							end else begin
								// The first item of the dump is produced in the next state.
								out_load   = 1'b0;
								start_dump = 1'b1;
								remain_d   = len_q;
							end
						end
						default: begin
							status_d = pcl_pkg::ST_OK;
						end
					endcase
				end
			end
			pcl_pkg::S_DUMP: begin
				// Emit the head and rotate the list by one entry.
				if (out_free) begin
					out_load     = 1'b1;
					item_value_d = entry[0];
					last_item_d  = (remain_q == 7'd1);
					remain_d     = remain_q - 7'd1;
					ctrl.op      = pcl_pkg::CH_ROTATE;
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Chain of entry cells.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [pcl_pkg::DATA_W-1:0] left_v;
		logic [pcl_pkg::DATA_W-1:0] right_v;
		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = entry[0];
		end else begin : g_mid_r
			assign right_v = entry[i+1];
		end
		pcl_cell #(
			.INDEX(i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_value  (value),
			.left_value (left_v),
			.right_value(right_v),
			.head_value (entry[0]),
			.entry      (entry[i])
		);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcl_pkg::S_IDLE;
			len_q       <= '0;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			len_q    <= len_d;
			remain_q <= remain_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q     <= status_d;
			count_q      <= len_d;
			item_value_q <= item_value_d;
			last_item_q  <= last_item_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign count      = count_q;
	assign item_value = item_value_q;
	assign last_item  = last_item_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count <= CAP)
		else $error("result count exceeds capacity");

	a_len_stable_dump: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcl_pkg::S_DUMP |=> $stable(len_q))
		else $error("length changed during a dump");

	a_dump_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_item |=> out_valid)
		else $error("dump stopped before its last item");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != pcl_pkg::ST_OK |-> item_value == '0)
		else $error("nonzero value on an error result");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int unsigned CAPACITY      = 32;
	localparam int          STALL_LIMIT   = 2000;
	localparam int          SETTLE_CYCLES = 10;
	localparam int          MAX_REPORTS   = 10;

	// One result item as the list controller should produce it.
	typedef struct {
		pcl_pkg::status_t                  status;
		logic [pcl_pkg::COUNT_W-1:0]       count;
		logic signed [pcl_pkg::DATA_W-1:0] item_value;
		logic                              last_item;
	} list_result_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	pcl_pkg::func_t                    func = pcl_pkg::FN_NOP;
	logic signed [pcl_pkg::DATA_W-1:0] value = '0;
	logic [pcl_pkg::POS_W-1:0]         position = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [pcl_pkg::STAT_W-1:0]        status;
	logic [pcl_pkg::COUNT_W-1:0]       count;
	logic signed [pcl_pkg::DATA_W-1:0] item_value;
	logic                              last_item;

	// Shadow copy of the list, head first, and the results still owed by the block.
	logic signed [pcl_pkg::DATA_W-1:0] shadow_entries[$];
	list_result_t                      pending_results[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	int items_sent = 0;
	int results_checked = 0;
	int full_hits = 0;
	int dump_results = 0;
	int stall_cycles = 0;

	positional_circular_list_core #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.value     (value),
		.position  (position),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.count     (count),
		.item_value(item_value),
		.last_item (last_item)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Queue one expected result item.
	function automatic void owe_result(pcl_pkg::status_t st,
			logic signed [pcl_pkg::DATA_W-1:0] v, logic last);
		list_result_t r;
		r.status     = st;
		r.count      = pcl_pkg::COUNT_W'(shadow_entries.size());
		r.item_value = v;
		r.last_item  = last;
		pending_results.push_back(r);
	endfunction

	// Apply one operation to the shadow list and queue the results it causes.
	function automatic void apply_list_op(pcl_pkg::func_t f,
			logic signed [pcl_pkg::DATA_W-1:0] v, logic [pcl_pkg::POS_W-1:0] p);
		int               len;
		int               pos;
		pcl_pkg::status_t st;
		len = shadow_entries.size();
		pos = int'(p);
		st  = pcl_pkg::ST_OK;
		case (f)
			pcl_pkg::FN_INS_FRONT, pcl_pkg::FN_INS_BACK: begin
				if (len >= CAPACITY)
					st = pcl_pkg::ST_FULL;
				else if (f == pcl_pkg::FN_INS_FRONT)
					shadow_entries.push_front(v);
				else
					shadow_entries.push_back(v);
			end
			pcl_pkg::FN_DEL_FRONT, pcl_pkg::FN_DEL_BACK: begin
				if (len == 0)
					st = pcl_pkg::ST_EMPTY;
				else if (f == pcl_pkg::FN_DEL_FRONT)
					void'(shadow_entries.pop_front());
				else
					void'(shadow_entries.pop_back());
			end
			pcl_pkg::FN_INS_AT: begin
				if (pos < 1 || pos > len + 1)
					st = pcl_pkg::ST_BADPOS;
				else if (len >= CAPACITY)
					st = pcl_pkg::ST_FULL;
				else
					shadow_entries.insert(pos - 1, v);
			end
			pcl_pkg::FN_DEL_AT: begin
				if (pos < 1 || pos > len)
					st = pcl_pkg::ST_BADPOS;
				else
					shadow_entries.delete(pos - 1);
			end
			pcl_pkg::FN_DUMP: begin
				// An empty dump still answers with a single item.
				if (len == 0) begin
					owe_result(pcl_pkg::ST_EMPTY, '0, 1'b1);
				end else begin
					for (int i = 0; i < len; i++)
						owe_result(pcl_pkg::ST_OK, shadow_entries[i], i == len - 1);
				end
				dump_results += (len == 0) ? 1 : len;
				return;
			end
			default: ;
		endcase
		if (st == pcl_pkg::ST_FULL)
			full_hits++;
		owe_result(st, '0, 1'b1);
	endfunction

	// Send one item, idling first at the current rate; returns at the accepting edge.
	task automatic send_item(pcl_pkg::func_t f, logic signed [pcl_pkg::DATA_W-1:0] v,
			logic [pcl_pkg::POS_W-1:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		value    <= v;
		position <= p;
		do
			@(negedge clk);
		while (!in_ready);
		apply_list_op(f, v, p);
		items_sent++;
		@(posedge clk);
	endtask

	// Hold the sender off until every owed result has been taken.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [pcl_pkg::DATA_W-1:0] random_value();
		case ($urandom_range(15))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom();
		endcase
	endfunction

	// Positions mostly near the valid range, sometimes anywhere the field allows.
	function automatic logic [pcl_pkg::POS_W-1:0] random_position();
		int len;
		len = shadow_entries.size();
		case ($urandom_range(9))
			0:       return pcl_pkg::POS_W'($urandom_range(0, 127));
			1:       return pcl_pkg::POS_W'(len + 2);
			default: return pcl_pkg::POS_W'($urandom_range(0, len + 1));
		endcase
	endfunction

	// Empty-list answers, one-entry positions, the value extremes and bad positions.
	task automatic test_directed();
		send_item(pcl_pkg::FN_DUMP, '0, '0);
		send_item(pcl_pkg::FN_DEL_FRONT, '0, '0);
		send_item(pcl_pkg::FN_DEL_BACK, '0, '0);
		send_item(pcl_pkg::FN_DEL_AT, '0, 7'd1);
		send_item(pcl_pkg::FN_INS_AT, 32'sd11, 7'd0);
		send_item(pcl_pkg::FN_INS_AT, 32'sd12, 7'd2);
		send_item(pcl_pkg::FN_NOP, 32'sd13, 7'd1);
		send_item(pcl_pkg::FN_INS_AT, 32'sd5, 7'd1);
		send_item(pcl_pkg::FN_INS_AT, -32'sd1, 7'd1);
		send_item(pcl_pkg::FN_DEL_AT, '0, 7'd2);
		send_item(pcl_pkg::FN_INS_AT, 32'sh7FFF_FFFF, 7'd2);
		send_item(pcl_pkg::FN_INS_FRONT, 32'sh8000_0000, '0);
		send_item(pcl_pkg::FN_INS_BACK, '0, 7'd127);
		send_item(pcl_pkg::FN_INS_AT, 32'sh5A5A_A5A5, 7'd3);
		send_item(pcl_pkg::FN_INS_AT, 32'sd1, pcl_pkg::POS_W'(shadow_entries.size() + 2));
		send_item(pcl_pkg::FN_DEL_AT, '0, 7'd0);
		send_item(pcl_pkg::FN_DEL_AT, '0, pcl_pkg::POS_W'(shadow_entries.size() + 1));
		send_item(pcl_pkg::FN_DUMP, -32'sd1, 7'd127);
		send_item(pcl_pkg::FN_DEL_AT, '0, 7'd3);
		send_item(pcl_pkg::FN_DEL_FRONT, '0, '0);
		send_item(pcl_pkg::FN_DEL_BACK, '0, '0);
		send_item(pcl_pkg::FN_INS_AT, 32'sd2, 7'd127);
		send_item(pcl_pkg::FN_DEL_AT, '0, 7'd64);
		send_item(pcl_pkg::FN_NOP, -32'sd1, 7'd127);
		send_item(pcl_pkg::FN_DUMP, '0, '0);
	endtask

	// Fill to capacity with random inserts, then press on the full list.
	task automatic test_fill_to_capacity();
		while (shadow_entries.size() < CAPACITY) begin
			case ($urandom_range(2))
				0:       send_item(pcl_pkg::FN_INS_FRONT, random_value(), random_position());
				1:       send_item(pcl_pkg::FN_INS_BACK, random_value(), random_position());
				default: send_item(pcl_pkg::FN_INS_AT, random_value(),
						pcl_pkg::POS_W'($urandom_range(1, shadow_entries.size() + 1)));
			endcase
		end
		send_item(pcl_pkg::FN_INS_FRONT, random_value(), '0);
		send_item(pcl_pkg::FN_INS_BACK, random_value(), '0);
		send_item(pcl_pkg::FN_INS_AT, random_value(), 7'd1);
		send_item(pcl_pkg::FN_INS_AT, random_value(), pcl_pkg::POS_W'(CAPACITY + 1));
		send_item(pcl_pkg::FN_INS_AT, random_value(), pcl_pkg::POS_W'(CAPACITY + 2));
		send_item(pcl_pkg::FN_DUMP, random_value(), random_position());
		send_item(pcl_pkg::FN_DEL_AT, '0, pcl_pkg::POS_W'(CAPACITY + 1));
		send_item(pcl_pkg::FN_DEL_AT, '0, pcl_pkg::POS_W'(CAPACITY));
		send_item(pcl_pkg::FN_INS_AT, random_value(), pcl_pkg::POS_W'(CAPACITY));
		send_item(pcl_pkg::FN_DUMP, '0, '0);
	endtask

	// Empty the list with random kinds of delete, then ask the empty list again.
	task automatic test_drain_to_empty();
		while (shadow_entries.size() > 0) begin
			case ($urandom_range(3))
				0:       send_item(pcl_pkg::FN_DEL_FRONT, random_value(), random_position());
				1:       send_item(pcl_pkg::FN_DEL_BACK, random_value(), random_position());
				default: send_item(pcl_pkg::FN_DEL_AT, random_value(),
						pcl_pkg::POS_W'($urandom_range(1, shadow_entries.size())));
			endcase
		end
		send_item(pcl_pkg::FN_DEL_FRONT, '0, '0);
		send_item(pcl_pkg::FN_DEL_BACK, '0, '0);
		send_item(pcl_pkg::FN_DEL_AT, '0, random_position());
		send_item(pcl_pkg::FN_DUMP, '0, '0);
	endtask

	// Random mix of every operation, with valid positions favored.
	task automatic test_random_mix(int n_items);
		pcl_pkg::func_t f;
		int             r;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(99);
			if (r < 18)
				f = pcl_pkg::FN_INS_FRONT;
			else if (r < 34)
				f = pcl_pkg::FN_INS_BACK;
			else if (r < 44)
				f = pcl_pkg::FN_DEL_FRONT;
			else if (r < 54)
				f = pcl_pkg::FN_DEL_BACK;
			else if (r < 72)
				f = pcl_pkg::FN_INS_AT;
			else if (r < 86)
				f = pcl_pkg::FN_DEL_AT;
			else if (r < 96)
				f = pcl_pkg::FN_DUMP;
			else
				f = pcl_pkg::FN_NOP;
			send_item(f, random_value(), random_position());
		end
	endtask

	// Receiver stalls at the current rate.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Compare each taken result item with the oldest one owed.
	always @(negedge clk) begin : result_check
		list_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result: status %0d count %0d value %0d last %0b",
						$time, status, count, item_value, last_item);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (status !== want.status || count !== want.count ||
						item_value !== want.item_value || last_item !== want.last_item) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$write("%0t: result mismatch: expected status %0d count %0d value %0d last %0b",
							$time, want.status, want.count, want.item_value, want.last_item);
						$display(", got status %0d count %0d value %0d last %0b",
							status, count, item_value, last_item);
					end
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel moves an item.
	always @(negedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender idles lightly while the receiver stalls often.
		send_idle_pct = 17;
		recv_idle_pct = 67;
		test_directed();
		test_fill_to_capacity();
		test_random_mix(20);
		wait_for_results();

		// Sender idles often while the receiver stalls lightly.
		send_idle_pct = 67;
		recv_idle_pct = 17;
		test_drain_to_empty();
		test_random_mix(15);
		wait_for_results();

		// No idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_fill_to_capacity();
		test_random_mix(10);
		test_drain_to_empty();

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d operations and checked %0d result items, %0d of them from dumps.",
			items_sent, results_checked, dump_results);
		$display("The list was full on %0d inserts; %0d result items disagreed.",
			full_hits, mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
